>>> rtl/imufd_pkg.sv
// imufd_pkg: shared types, constants and the crc step for the imu frame decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps
`default_nettype none

package imufd_pkg;

    // frame layout constants
    localparam logic [7:0]  HDR0            = 8'h5A;
    localparam logic [7:0]  HDR1            = 8'hA5;
    localparam logic [7:0]  TAG_RATE        = 8'hB0;
    localparam logic [7:0]  TAG_ANGLE       = 8'hD0;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [5:0]  FRAME_LEN_RESET = 6'd20;
    localparam int          WIN_HIST        = 6;
    localparam int          TAG_FIRST_POS   = 12;
    localparam int          PAYLOAD_START   = 6;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;

    // input word
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [15:0]        good_frames;
        logic [15:0]        bad_frames;
    } t_out_word;

    // one byte of crc-16/xmodem, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/imufd_parser.sv
// imufd_parser: per-burst state, header/length/crc capture, tag window and held values
// depends on imufd_pkg
`timescale 1ns / 1ps
`default_nettype none

module imufd_parser #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire imufd_pkg::t_in_word  i_word,
    input  wire logic [5:0]           i_frame_length,
    output logic                      o_has_result,
    output imufd_pkg::t_out_word      o_result
);
    import imufd_pkg::*;

    localparam int IW = $clog2(BUFFER_BYTES);
    localparam int CW = IW + 1;
    localparam int MW = (CW > 6) ? CW : 6;

    // burst state
    logic [IW-1:0] r_idx,      n_idx;
    logic [7:0]    r_win [0:WIN_HIST-1];
    logic [7:0]    n_win [0:WIN_HIST-1];
    logic [15:0]   r_crc,      n_crc;
    logic [15:0]   r_len,      n_len;
    logic [15:0]   r_rcrc,     n_rcrc;
    logic          r_hdr_bad,  n_hdr_bad;
    logic [15:0]   r_pang [0:2];
    logic [15:0]   n_pang [0:2];
    logic [15:0]   r_prate [0:2];
    logic [15:0]   n_prate [0:2];
    logic [1:0]    r_seen,     n_seen;
    // held state
    logic [15:0]   r_hang [0:2];
    logic [15:0]   n_hang [0:2];
    logic [15:0]   r_hrate [0:2];
    logic [15:0]   n_hrate [0:2];
    logic [15:0]   r_good,     n_good;
    logic [15:0]   r_bad,      n_bad;

    logic [7:0]    w_b;
    logic [CW-1:0] w_count;
    logic          w_full;
    logic          w_clear;
    logic          w_crc_en;
    logic [1:0]    w_status;
    logic [7:0]    w_cur [0:WIN_HIST];

    always_comb begin
        w_b     = i_word.rx_byte;
        w_count = {1'b0, r_idx} + CW'(1);
        w_full  = (w_count >= CW'(BUFFER_BYTES));

        // shifted window, index 0 is the newest byte
        w_cur[0] = w_b;
        for (int k = 1; k <= WIN_HIST; k++) begin
            w_cur[k] = r_win[k-1];
        end
        for (int k = 0; k < WIN_HIST; k++) begin
            n_win[k] = w_cur[k];
        end

        // header, length and stored crc capture
        n_hdr_bad = r_hdr_bad
                  | ((r_idx == IW'(0)) && (w_b != HDR0))
                  | ((r_idx == IW'(1)) && (w_b != HDR1));
        n_len  = r_len;
        n_rcrc = r_rcrc;
        if (r_idx == IW'(2)) n_len[7:0]   = w_b;
        if (r_idx == IW'(3)) n_len[15:8]  = w_b;
        if (r_idx == IW'(4)) n_rcrc[7:0]  = w_b;
        if (r_idx == IW'(5)) n_rcrc[15:8] = w_b;

        // crc over the sync bytes, the length header and the declared payload
        w_crc_en = (r_idx < IW'(4))
                 || ((r_idx >= IW'(PAYLOAD_START))
                     && (17'(r_idx) < (17'(n_len) + 17'(PAYLOAD_START))));
        n_crc = w_crc_en ? crc_byte(r_crc, w_b) : r_crc;

        // tag scan, rate tag wins over angle tag at one position
        n_pang  = r_pang;
        n_prate = r_prate;
        n_seen  = r_seen;
        if (r_idx >= IW'(TAG_FIRST_POS)) begin
            if (w_cur[6] == TAG_RATE) begin
                n_prate[0] = {w_cur[4], w_cur[5]};
                n_prate[1] = {w_cur[2], w_cur[3]};
                n_prate[2] = {w_cur[0], w_cur[1]};
                n_seen[0]  = 1'b1;
            end else if (w_cur[6] == TAG_ANGLE) begin
                n_pang[0]  = {w_cur[4], w_cur[5]};
                n_pang[1]  = {w_cur[2], w_cur[3]};
                n_pang[2]  = {w_cur[0], w_cur[1]};
                n_seen[1]  = 1'b1;
            end
        end

        // frame verdict
        if ((w_count < CW'(2)) || n_hdr_bad) begin
            w_status = ST_BAD_HDR;
        end else if (((17'(n_len) + 17'(PAYLOAD_START)) > 17'(w_count))
                     || (n_crc != n_rcrc)) begin
            w_status = ST_BAD_CRC;
        end else begin
            w_status = ST_OK;
        end

        o_has_result = !w_full && i_word.end_of_frame
                     && (MW'(w_count) == MW'(i_frame_length));

        // held values and counters
        n_hang  = r_hang;
        n_hrate = r_hrate;
        n_good  = r_good;
        n_bad   = r_bad;
        if (o_has_result) begin
            if (w_status == ST_OK) begin
                if (n_seen[0]) n_hrate = n_prate;
                if (n_seen[1]) n_hang  = n_pang;
                n_good = r_good + 16'd1;
            end else begin
                n_bad = r_bad + 16'd1;
            end
        end

        // burst ends on buffer full or on the end mark
        w_clear = w_full || i_word.end_of_frame;
        n_idx   = w_count[IW-1:0];
        if (w_clear) begin
            n_idx     = '0;
            n_crc     = '0;
            n_len     = '0;
            n_rcrc    = '0;
            n_hdr_bad = 1'b0;
            n_seen    = '0;
            for (int k = 0; k < WIN_HIST; k++) n_win[k] = '0;
            for (int k = 0; k < 3; k++) begin
                n_pang[k]  = '0;
                n_prate[k] = '0;
            end
        end

        // result word carries the values after the update
        o_result.status      = w_status;
        o_result.angle_x     = n_hang[0];
        o_result.angle_y     = n_hang[1];
        o_result.angle_z     = n_hang[2];
        o_result.rate_x      = n_hrate[0];
        o_result.rate_y      = n_hrate[1];
        o_result.rate_z      = n_hrate[2];
        o_result.good_frames = n_good;
        o_result.bad_frames  = n_bad;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_crc     <= '0;
            r_len     <= '0;
            r_rcrc    <= '0;
            r_hdr_bad <= 1'b0;
            r_seen    <= '0;
            r_good    <= '0;
            r_bad     <= '0;
            for (int k = 0; k < WIN_HIST; k++) r_win[k] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pang[k]  <= '0;
                r_prate[k] <= '0;
                r_hang[k]  <= '0;
                r_hrate[k] <= '0;
            end
        end else if (i_adv) begin
            r_idx     <= n_idx;
            r_crc     <= n_crc;
            r_len     <= n_len;
            r_rcrc    <= n_rcrc;
            r_hdr_bad <= n_hdr_bad;
            r_seen    <= n_seen;
            r_good    <= n_good;
            r_bad     <= n_bad;
            r_win     <= n_win;
            r_pang    <= n_pang;
            r_prate   <= n_prate;
            r_hang    <= n_hang;
            r_hrate   <= n_hrate;
        end
    end

endmodule

`default_nettype wire

>>> rtl/imufd_out_reg.sv
// imufd_out_reg: result register with valid/ready toward the consumer
// depends on imufd_pkg
`timescale 1ns / 1ps
`default_nettype none

module imufd_out_reg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire imufd_pkg::t_out_word i_word,
    output logic                      o_free,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output imufd_pkg::t_out_word      o_word
);
    import imufd_pkg::*;

    logic      r_valid, n_valid;
    t_out_word r_word;

    // slot is free when empty or being drained this cycle
    always_comb begin
        o_free  = !r_valid || i_ready;
        n_valid = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload loads only into a free slot
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

>>> rtl/imu_frame_decoder_crc16_top.sv
// path: an accepted word passes the input register and the parser; its result word is registered in the result register
// throughput: one byte word per cycle; the input register stalls only when a
//   frame result meets a full, unread result register
// reset (synchronous, active low) clears all burst state, held values, counters
//   and the frame length register (back to 20); no clearing pass
// imu_frame_decoder_crc16_top: input register, frame length register, parser, result register
// depends on imufd_pkg, imufd_parser, imufd_out_reg
`timescale 1ns / 1ps
`default_nettype none

module imu_frame_decoder_crc16_top #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire imufd_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output imufd_pkg::t_out_word      o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [5:0]           i_cfg_data
);
    import imufd_pkg::*;

    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic [5:0] r_frame_length;
    logic      w_has_result;
    t_out_word w_result;
    logic      w_out_free;
    logic      w_s1_adv;

    // stage advances unless its result would hit a full result register
    assign w_s1_adv   = r_s1_valid && (!w_has_result || w_out_free);
    assign o_in_ready = !r_s1_valid || w_s1_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
    end

    // frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FRAME_LEN_RESET;
        end else if (i_cfg_we) begin
            r_frame_length <= i_cfg_data;
        end
    end

    imufd_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_s1_adv),
        .i_word         (r_s1_word),
        .i_frame_length (r_frame_length),
        .o_has_result   (w_has_result),
        .o_result       (w_result)
    );

    imufd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_adv && w_has_result),
        .i_word  (w_result),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

`default_nettype wire

>>> rtl/imufd_checker.sv
// imufd_checker: port-level assertions for the imu frame decoder, bound to the top
// depends on imufd_pkg and imu_frame_decoder_crc16_top
`timescale 1ns / 1ps
`default_nettype none

module imufd_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire imufd_pkg::t_out_word o_out_word,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready
);
    import imufd_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == ST_OK || o_out_word.status == ST_BAD_HDR
                         || o_out_word.status == ST_BAD_CRC))
        else $error("undefined status code");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind imu_frame_decoder_crc16_top imufd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_word  (o_out_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

`default_nettype wire
